/* hw/rtl/pfal_pkg.sv */
// ----------------------------------------------------------------------------
// pfal_pkg: shared types and constants for the PIN / fingerprint access lock
// Request, result and configuration structs, request and event codes, and
// the helpers for the stored PIN digits and millisecond-to-second scaling.
// ----------------------------------------------------------------------------
package pfal_pkg;

  localparam int PIN_DIGITS    = 6;
  localparam int STORED_DIGITS = 6;
  localparam int LEN_W         = $clog2(PIN_DIGITS + 1);
  localparam int IDX_W         = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STORED_PIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_FACTOR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_MS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STAR_LIMIT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_THRESHOLD = 3'd5;

  // register reset values
  localparam logic [23:0] RST_STORED_PIN     = 24'h123456;
  localparam logic        RST_TWO_FACTOR     = 1'b0;
  localparam logic [3:0]  RST_MAX_FAILURES   = 4'd5;
  localparam logic [15:0] RST_LOCKOUT_MS     = 16'd30000;
  localparam logic [4:0]  RST_STAR_LIMIT     = 5'd12;
  localparam logic [4:0]  RST_HASH_THRESHOLD = 5'd12;

  // request kinds
  localparam logic [1:0] REQ_KEY    = 2'd0;
  localparam logic [1:0] REQ_FINGER = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // key codes
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_STAR      = 4'd10;
  localparam logic [3:0] KEY_HASH      = 4'd11;

  // event codes
  localparam logic [3:0] EV_NONE          = 4'd0;
  localparam logic [3:0] EV_DIGIT         = 4'd1;
  localparam logic [3:0] EV_PIN_GRANT     = 4'd2;
  localparam logic [3:0] EV_FINGER_GRANT  = 4'd3;
  localparam logic [3:0] EV_PIN_HALF      = 4'd4;
  localparam logic [3:0] EV_FINGER_HALF   = 4'd5;
  localparam logic [3:0] EV_BAD_PIN       = 4'd6;
  localparam logic [3:0] EV_PIN_LOCKS     = 4'd7;
  localparam logic [3:0] EV_PIN_REJECT    = 4'd8;
  localparam logic [3:0] EV_BAD_FINGER    = 4'd9;
  localparam logic [3:0] EV_FINGER_LOCKS  = 4'd10;
  localparam logic [3:0] EV_FINGER_REJECT = 4'd11;
  localparam logic [3:0] EV_CHANGE_PIN    = 4'd12;
  localparam logic [3:0] EV_ADMIN         = 4'd13;
  localparam logic [3:0] EV_CLEARED       = 4'd14;

  // x / 1000 == (x * 67109) >> 26, exact for every 16-bit x
  localparam logic [16:0] MS_RECIP = 17'd67109;
  localparam int          MS_SHIFT = 26;

  typedef struct packed {
    logic [23:0] stored_pin;
    logic        two_factor_mode;
    logic [3:0]  max_failures;
    logic [15:0] lockout_ms;
    logic [4:0]  star_limit;
    logic [4:0]  hash_threshold;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] key_code;
    logic       finger_matched;
    logic [7:0] finger_id;
  } item_t;

  typedef struct packed {
    logic [3:0] event_code;
    logic       unlock_pulse;
    logic [3:0] tries_left;
    logic [6:0] lock_seconds_left;
    logic [2:0] entry_count;
    logic       pin_ok_flag;
    logic       finger_ok_flag;
    logic [7:0] granted_id;
  } result_t;

  function automatic logic [3:0] stored_digit(input logic [23:0] pin, input int i);
    logic [23:0] sh;
    sh = 24'd0;
    if (i < STORED_DIGITS) begin
      sh = pin >> (4 * (STORED_DIGITS - 1 - i));
    end
    return sh[3:0];
  endfunction

  function automatic logic [6:0] ms_to_secs(input logic [15:0] ms);
    logic [32:0] prod;
    prod = {17'd0, ms} * {16'd0, MS_RECIP};
    return prod[MS_SHIFT +: 7];
  endfunction

endpackage

/* hw/rtl/pfal_core.sv */
// ----------------------------------------------------------------------------
// pfal_core: lock state and per-request decision logic
// Holds entry buffer, press counters, failure counters, lock timers and
// verified bits; computes the result for one request combinationally.
// ----------------------------------------------------------------------------
module pfal_core
  import pfal_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [3:0]       entry_digits_r [PIN_DIGITS];
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [4:0]       star_r, star_nxt;
  logic [4:0]       hash_r, hash_nxt;
  logic [3:0]       pin_fails_r, pin_fails_nxt;
  logic [3:0]       fng_fails_r, fng_fails_nxt;
  logic [15:0]      pin_timer_r, pin_timer_nxt;
  logic [15:0]      fng_timer_r, fng_timer_nxt;
  logic             pin_ok_r, pin_ok_nxt;
  logic             fng_ok_r, fng_ok_nxt;

  logic        wr_digit;
  logic        pin_match;
  logic [3:0]  ev;
  logic        unlock;
  logic [3:0]  tries;
  logic        secs_en;
  logic [15:0] secs_src;
  logic [7:0]  gid;

  // full-length compare, with the incoming key in the slot it completes
  always_comb begin
    logic [3:0] d;
    pin_match = 1'b1;
    for (int i = 0; i < PIN_DIGITS; i++) begin
      d = (LEN_W'(i) == len_r) ? item.key_code : entry_digits_r[i];
      if (d != stored_digit(cfg.stored_pin, i)) begin
        pin_match = 1'b0;
      end
    end
  end

  always_comb begin
    logic [4:0] star_inc;
    logic [4:0] hash_inc;
    logic [3:0] pin_inc;
    logic [3:0] fng_inc;
    logic       pin_check;
    logic       pin_full;
    star_inc = (star_r != 5'd31) ? star_r + 5'd1 : star_r;
    hash_inc = (hash_r != 5'd31) ? hash_r + 5'd1 : hash_r;
    pin_inc  = (pin_fails_r != 4'hF) ? pin_fails_r + 4'd1 : pin_fails_r;
    fng_inc  = (fng_fails_r != 4'hF) ? fng_fails_r + 4'd1 : fng_fails_r;
    pin_check     = 1'b0;
    pin_full      = 1'b0;
    len_nxt       = len_r;
    star_nxt      = star_r;
    hash_nxt      = hash_r;
    pin_fails_nxt = pin_fails_r;
    fng_fails_nxt = fng_fails_r;
    pin_timer_nxt = pin_timer_r;
    fng_timer_nxt = fng_timer_r;
    pin_ok_nxt    = pin_ok_r;
    fng_ok_nxt    = fng_ok_r;
    wr_digit      = 1'b0;
    ev            = EV_NONE;
    unlock        = 1'b0;
    tries         = 4'd0;
    secs_en       = 1'b0;
    secs_src      = 16'd0;
    gid           = 8'd0;

    if (step_en) begin
      unique case (item.req_type)
        REQ_KEY: begin
          priority if (pin_timer_r != 16'd0) begin
            ev       = EV_PIN_REJECT;
            secs_en  = 1'b1;
            secs_src = pin_timer_r;
          end else if (item.key_code == KEY_STAR) begin
            if (star_inc >= cfg.star_limit) begin
              star_nxt = 5'd0;
              ev       = EV_CHANGE_PIN;
            end else begin
              star_nxt = star_inc;
              len_nxt  = '0;
              ev       = EV_CLEARED;
            end
          end else if (item.key_code == KEY_HASH) begin
            if (hash_inc >= cfg.hash_threshold) begin
              hash_nxt = 5'd0;
              ev       = EV_ADMIN;
            end else begin
              hash_nxt = hash_inc;
              // a short entry never matches
              if (len_r != '0) begin
                pin_check = 1'b1;
              end
            end
          end else if (item.key_code <= KEY_DIGIT_MAX) begin
            star_nxt = 5'd0;
            hash_nxt = 5'd0;
            if (len_r < LEN_W'(PIN_DIGITS)) begin
              wr_digit = 1'b1;
              if (len_r == LEN_W'(PIN_DIGITS - 1)) begin
                pin_check = 1'b1;
                pin_full  = 1'b1;
              end else begin
                len_nxt = len_r + LEN_W'(1);
                ev      = EV_DIGIT;
              end
            end
          end else begin
            // key codes above the hash key are ignored
          end
        end
        REQ_FINGER: begin
          priority if (fng_timer_r != 16'd0) begin
            ev       = EV_FINGER_REJECT;
            secs_en  = 1'b1;
            secs_src = fng_timer_r;
          end else if (!item.finger_matched) begin
            if (fng_inc >= cfg.max_failures) begin
              fng_timer_nxt = cfg.lockout_ms;
              fng_fails_nxt = (cfg.lockout_ms == 16'd0) ? 4'd0 : fng_inc;
              ev            = EV_FINGER_LOCKS;
              secs_en       = 1'b1;
              secs_src      = cfg.lockout_ms;
            end else begin
              fng_fails_nxt = fng_inc;
              tries         = cfg.max_failures - fng_inc;
              ev            = EV_BAD_FINGER;
            end
          end else begin
            fng_fails_nxt = 4'd0;
            if (cfg.two_factor_mode && !pin_ok_r) begin
              fng_ok_nxt = 1'b1;
              ev         = EV_FINGER_HALF;
            end else begin
              pin_ok_nxt = 1'b0;
              fng_ok_nxt = 1'b0;
              unlock     = 1'b1;
              gid        = item.finger_id;
              ev         = EV_FINGER_GRANT;
            end
          end
        end
        REQ_TICK: begin
          if (pin_timer_r != 16'd0) begin
            pin_timer_nxt = pin_timer_r - 16'd1;
            if (pin_timer_r == 16'd1) begin
              pin_fails_nxt = 4'd0;
            end
          end
          if (fng_timer_r != 16'd0) begin
            fng_timer_nxt = fng_timer_r - 16'd1;
            if (fng_timer_r == 16'd1) begin
              fng_fails_nxt = 4'd0;
            end
          end
        end
        default: ;
      endcase
    end

    if (pin_check) begin
      len_nxt = '0;
      if (pin_full && pin_match) begin
        if (cfg.two_factor_mode && !fng_ok_r) begin
          pin_ok_nxt = 1'b1;
          ev         = EV_PIN_HALF;
        end else begin
          pin_fails_nxt = 4'd0;
          pin_ok_nxt    = 1'b0;
          fng_ok_nxt    = 1'b0;
          unlock        = 1'b1;
          ev            = EV_PIN_GRANT;
        end
      end else if (pin_inc >= cfg.max_failures) begin
        pin_timer_nxt = cfg.lockout_ms;
        pin_fails_nxt = (cfg.lockout_ms == 16'd0) ? 4'd0 : pin_inc;
        ev            = EV_PIN_LOCKS;
        secs_en       = 1'b1;
        secs_src      = cfg.lockout_ms;
      end else begin
        pin_fails_nxt = pin_inc;
        tries         = cfg.max_failures - pin_inc;
        ev            = EV_BAD_PIN;
      end
    end
  end

  always_comb begin
    res.event_code        = ev;
    res.unlock_pulse      = unlock;
    res.tries_left        = tries;
    res.lock_seconds_left = secs_en ? ms_to_secs(secs_src) : 7'd0;
    res.entry_count       = 3'(len_nxt);
    res.pin_ok_flag       = pin_ok_nxt;
    res.finger_ok_flag    = fng_ok_nxt;
    res.granted_id        = gid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      star_r      <= 5'd0;
      hash_r      <= 5'd0;
      pin_fails_r <= 4'd0;
      fng_fails_r <= 4'd0;
      pin_timer_r <= 16'd0;
      fng_timer_r <= 16'd0;
      pin_ok_r    <= 1'b0;
      fng_ok_r    <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      star_r      <= star_nxt;
      hash_r      <= hash_nxt;
      pin_fails_r <= pin_fails_nxt;
      fng_fails_r <= fng_fails_nxt;
      pin_timer_r <= pin_timer_nxt;
      fng_timer_r <= fng_timer_nxt;
      pin_ok_r    <= pin_ok_nxt;
      fng_ok_r    <= fng_ok_nxt;
    end
  end

  // entry buffer, no reset: only slots below len_r are ever read
  always_ff @(posedge clk) begin
    if (wr_digit) begin
      entry_digits_r[len_r[IDX_W-1:0]] <= item.key_code;
    end
  end

  a_len_below_full: assert property (@(posedge clk) disable iff (!rst_n)
    len_r < LEN_W'(PIN_DIGITS))
    else $error("entry length reached full PIN without a check");

  a_tick_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && item.req_type == REQ_TICK && pin_timer_r != 16'd0)
      |=> (pin_timer_r == $past(pin_timer_r) - 16'd1))
    else $error("PIN lock timer did not count down by one on a tick");

  a_locked_keys_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && item.req_type == REQ_KEY && pin_timer_r != 16'd0)
      |=> ($stable(len_r) && $stable(pin_fails_r) && $stable(star_r) && $stable(hash_r)))
    else $error("key press changed PIN state while locked");

  a_grant_clears_halves: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res.unlock_pulse) |-> (!res.pin_ok_flag && !res.finger_ok_flag))
    else $error("grant left a half-verified bit set");

endmodule

/* hw/rtl/pin_fingerprint_access_lock.sv */
// ----------------------------------------------------------------------------
// pin_fingerprint_access_lock: keypad PIN and fingerprint door lock
// Stream-in requests (key, fingerprint result, 1 ms tick), one result each.
//
// Usage:
//   in_*   request stream. in_tuser = request kind, in_tdata = key code,
//          match flag and template id. Every request gives exactly one
//          result on the out_* stream, in order.
//   out_*  result stream. out_tuser = event code, out_tdata = the result
//          fields (unlock pulse, tries, lock seconds, entry count, flags,
//          granted id).
//   cfg_*  register writes (index, data); always ready, applied at the
//          next edge. Write only while no request is in flight.
//   Path: input register, combinational decision logic, result register.
//   Throughput: one request per cycle while out_tready does not stall,
//   set by the combinational decision logic between the two registers.
//   Stall: while out_tready is low the result register holds; one more
//   request is buffered in the input register, then in_tready drops.
//   Reset (rst_n low, synchronous): registers return to defaults (PIN
//   123456, single factor, 5 tries, 30 s lock, thresholds 12), counters,
//   timers and verified bits clear, both streams empty.
// ----------------------------------------------------------------------------
module pin_fingerprint_access_lock
  import pfal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [3:0] key_code, [4] finger_matched,
                                            // [12:5] finger_id, [15:13] zero
  input  logic [1:0]            in_tuser,   // [1:0] req_type
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [0] unlock_pulse, [4:1] tries_left,
                                            // [11:5] lock_seconds_left,
                                            // [14:12] entry_count, [15] pin_ok_flag,
                                            // [16] finger_ok_flag, [24:17] granted_id,
                                            // [31:25] zero
  output logic [3:0]            out_tuser,  // [3:0] event_code
  // register write port
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg_r;
  item_t   in_item_r;
  logic    in_valid_r;
  result_t out_res_r;
  logic    out_valid_r;
  result_t res;

  logic advance;  // result register can take a new value
  logic step_en;  // the held request is processed this cycle

  assign advance   = !out_valid_r || out_tready;
  assign step_en   = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stored_pin      <= RST_STORED_PIN;
      cfg_r.two_factor_mode <= RST_TWO_FACTOR;
      cfg_r.max_failures    <= RST_MAX_FAILURES;
      cfg_r.lockout_ms      <= RST_LOCKOUT_MS;
      cfg_r.star_limit      <= RST_STAR_LIMIT;
      cfg_r.hash_threshold  <= RST_HASH_THRESHOLD;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STORED_PIN:     cfg_r.stored_pin      <= cfg_data[23:0];
        CFG_TWO_FACTOR:     cfg_r.two_factor_mode <= cfg_data[0];
        CFG_MAX_FAILURES:   cfg_r.max_failures    <= cfg_data[3:0];
        CFG_LOCKOUT_MS:     cfg_r.lockout_ms      <= cfg_data[15:0];
        CFG_STAR_LIMIT:     cfg_r.star_limit      <= cfg_data[4:0];
        CFG_HASH_THRESHOLD: cfg_r.hash_threshold  <= cfg_data[4:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (step_en) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.req_type       <= in_tuser;
      in_item_r.key_code       <= in_tdata[3:0];
      in_item_r.finger_matched <= in_tdata[4];
      in_item_r.finger_id      <= in_tdata[12:5];
    end
  end

  pfal_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_item_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.event_code;
  assign out_tdata  = {7'd0,
                       out_res_r.granted_id,
                       out_res_r.finger_ok_flag,
                       out_res_r.pin_ok_flag,
                       out_res_r.entry_count,
                       out_res_r.lock_seconds_left,
                       out_res_r.tries_left,
                       out_res_r.unlock_pulse};

endmodule
